// ===== sv/cpts_pkg.sv =====
// Package for the counter-decay priority task scheduler.
// Holds the transfer structs, action codes and run-state codes. No dependencies.
`timescale 1ns / 1ps
package cpts_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_SCHED = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] ST_RUNNING       = 3'd0;
  localparam logic [2:0] ST_INTERRUPTIBLE = 3'd1;

  localparam logic [31:0] SIG_ALARM_BIT   = 32'h0000_2000;
  localparam logic [31:0] SIG_UNBLOCKABLE = 32'h0004_0100;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic        in_present;
    logic [2:0]  in_run_state;
    logic [7:0]  in_slice_count;
    logic [6:0]  in_priority;
    logic [31:0] in_alarm_time;
    logic [31:0] in_pending;
    logic [31:0] in_masked;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [5:0]  chosen_task;
    logic        out_present;
    logic [2:0]  out_run_state;
    logic [7:0]  out_slice_count;
    logic [6:0]  out_priority;
    logic [31:0] out_alarm_time;
    logic [31:0] out_pending;
    logic [31:0] out_masked;
  } rsp_t;

  // One slot record as stored in the table memory.
  typedef struct packed {
    logic [2:0]  run_state;
    logic [7:0]  slice_count;
    logic [6:0]  priority_v;
    logic [31:0] alarm_time;
    logic [31:0] pending;
    logic [31:0] masked;
  } slot_t;

endpackage

// ===== sv/cpts_slot_unit.sv =====
// Shared per-slot update unit for the task scheduler: alarm/signal wakeup and
// counter refill for one slot record. Depends on cpts_pkg.
`timescale 1ns / 1ps
module cpts_slot_unit import cpts_pkg::*; (
  input  slot_t       slot_i,
  input  logic [31:0] now_i,
  input  logic        refill_i,
  output slot_t       slot_o
);
  always_comb begin
    slot_o = slot_i;
    if (refill_i) begin
      slot_o.slice_count = (slot_i.slice_count >> 1) + {1'b0, slot_i.priority_v};
    end else begin
      if (slot_i.alarm_time != '0 && slot_i.alarm_time < now_i) begin
        slot_o.pending    = slot_i.pending | SIG_ALARM_BIT;
        slot_o.alarm_time = '0;
      end
      if ((slot_o.pending & ~(slot_i.masked & ~SIG_UNBLOCKABLE)) != '0 &&
          slot_i.run_state == ST_INTERRUPTIBLE) begin
        slot_o.run_state = ST_RUNNING;
      end
    end
  end
endmodule

// ===== sv/counter_priority_task_scheduler_unit.sv =====
// Top level of the counter-decay priority task scheduler.
// Uses cpts_pkg and cpts_slot_unit; slot table is an internal memory.
//
// Usage: one input channel (req_valid_i/req_stall_o/req_i) carries actions,
// one output channel (rsp_valid_o/rsp_stall_i/rsp_o) returns exactly one
// result per accepted transfer.
// Load, read and the unused action pass through the accept state, the memory
// read state, then the result register. Schedule walks slots NUM_TASKS-1
// down to 1 up to four times (signal pass, pick pass, optional refill pass
// and second pick), each slot taking a memory read, then an update through
// the shared slot unit or a pick compare; the registered memory read stands
// in front of the one shared slot unit.
// The block takes one item at a time: req_stall_o is high from acceptance
// until the result is loaded into the result register. When the receiver
// stalls, the result register holds its value; a new transfer may be taken
// meanwhile, and its result waits until the register frees.
// Reset clears the present bits (flip-flops) and the control state; the other
// slot fields are undefined until loaded. No clearing pass is needed.
`timescale 1ns / 1ps
module counter_priority_task_scheduler_unit import cpts_pkg::*; #(
  parameter int NUM_TASKS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);
  localparam int IW = $clog2(NUM_TASKS);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SIG, S_PICK, S_REFILL, S_DONE
  } state_e;

  state_e state_q;
  req_t   req_q;
  rsp_t   rsp_q;
  rsp_t   rsp_d;
  logic   rsp_valid_q;
  logic   present_q [NUM_TASKS];
  slot_t  mem [NUM_TASKS];
  slot_t  rdata_q;
  logic [IW-1:0] idx_q;
  logic   phase_q;    // 0: issue read, 1: data available
  logic   second_q;   // pick pass follows a refill
  logic [8:0] best_q; // bit 8 set: none found yet
  logic [IW-1:0] chosen_q;
  slot_t  upd;
  logic   in_range;
  logic [IW-1:0] req_idx;

  assign in_range = ({3'b0, req_q.slot} < 9'(NUM_TASKS));
  assign req_idx  = IW'(req_q.slot);

  cpts_slot_unit u_slot (
    .slot_i  (rdata_q),
    .now_i   (req_q.now),
    .refill_i(state_q == S_REFILL),
    .slot_o  (upd)
  );

  // Memory: one read and one write per cycle, read data registered.
  logic        mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  slot_t       mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = upd;
    mem_ra = idx_q;
    if (state_q == S_RD) begin
      mem_ra = req_idx;
      mem_we = (req_q.action == ACT_LOAD) && in_range;
      mem_wa = req_idx;
      mem_wd = '{req_q.in_run_state, req_q.in_slice_count, req_q.in_priority,
                 req_q.in_alarm_time, req_q.in_pending, req_q.in_masked};
    end else if ((state_q == S_SIG || state_q == S_REFILL) && phase_q &&
                 present_q[idx_q]) begin
      mem_we = 1'b1;
    end else if (state_q == S_DONE) begin
      // Hold the read slot's data while the result register is busy.
      mem_ra = req_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  // Result of the current transfer: pick for schedule, slot fields for read, zeros otherwise.
  always_comb begin
    rsp_d = '0;
    if (req_q.action == ACT_SCHED) begin
      rsp_d.chosen_task = 6'(chosen_q);
    end else if (req_q.action == ACT_READ && in_range) begin
      rsp_d.out_present     = present_q[req_idx];
      rsp_d.out_run_state   = rdata_q.run_state;
      rsp_d.out_slice_count = rdata_q.slice_count;
      rsp_d.out_priority    = rdata_q.priority_v;
      rsp_d.out_alarm_time  = rdata_q.alarm_time;
      rsp_d.out_pending     = rdata_q.pending;
      rsp_d.out_masked      = rdata_q.masked;
    end
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      second_q    <= 1'b0;
      idx_q       <= '0;
      best_q      <= 9'h100;
      chosen_q    <= '0;
      for (int i = 0; i < NUM_TASKS; i++) present_q[i] <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          // Load writes here; read data arrives next cycle.
          if (req_q.action == ACT_LOAD && in_range)
            present_q[req_idx] <= req_q.in_present;
          if (req_q.action == ACT_SCHED) begin
            idx_q    <= IW'(NUM_TASKS - 1);
            phase_q  <= 1'b0;
            second_q <= 1'b0;
            state_q  <= S_SIG;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SIG, S_REFILL: begin
          // Read slot, then write back the updated record.
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            if (idx_q == IW'(1)) begin
              idx_q   <= IW'(NUM_TASKS - 1);
              best_q  <= 9'h100;
              chosen_q <= '0;
              second_q <= (state_q == S_REFILL);
              state_q <= S_PICK;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        S_PICK: begin
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            if (present_q[idx_q] && rdata_q.run_state == ST_RUNNING &&
                (best_q[8] || {1'b0, rdata_q.slice_count} > best_q)) begin
              best_q   <= {1'b0, rdata_q.slice_count};
              chosen_q <= idx_q;
            end
            if (idx_q == IW'(1)) begin
              if (!second_q && best_q == 9'd0 &&
                  !(present_q[idx_q] && rdata_q.run_state == ST_RUNNING &&
                    rdata_q.slice_count != 8'd0)) begin
                idx_q   <= IW'(NUM_TASKS - 1);
                state_q <= S_REFILL;
              end else if (!second_q && best_q[8] && present_q[idx_q] &&
                           rdata_q.run_state == ST_RUNNING &&
                           rdata_q.slice_count == 8'd0) begin
                idx_q   <= IW'(NUM_TASKS - 1);
                state_q <= S_REFILL;
              end else begin
                state_q <= S_DONE;
              end
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid_q || !rsp_stall_i) begin
            rsp_q       <= rsp_d;
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (rsp_valid_q && !rsp_stall_i && !(state_q == S_DONE))
        rsp_valid_q <= 1'b0;
    end
  end
endmodule
